### sv/pfma_pkg.sv
`default_nettype none
package pfma_pkg;

  localparam int SLOTS      = 16;
  localparam int FREE_DEPTH = 256;
  localparam int ENTRIES    = 32;

  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_AW  = $clog2(ENTRIES);
  localparam int TBL_AW  = SLOT_AW + ENT_AW;
  localparam int FS_AW   = $clog2(FREE_DEPTH);
  localparam int FC_W    = $clog2(FREE_DEPTH + 1);

  localparam logic [4:0] BANK_LIMIT = 5'd29;
  localparam logic [4:0] LAST_BANK  = 5'd28;
  localparam logic [4:0] ENT_COMMON = 5'd29;
  localparam logic [4:0] ENT_IO_LO  = 5'd30;
  localparam logic [4:0] ENT_IO_HI  = 5'd31;
  localparam logic [7:0] COMMON_PAGE = 8'h1D;
  localparam logic [7:0] IO_PAGE_LO  = 8'h7E;
  localparam logic [7:0] IO_PAGE_HI  = 8'h7F;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_ALLOC   = 3'd1;
  localparam logic [2:0] CMD_FREE    = 3'd2;
  localparam logic [2:0] CMD_REALLOC = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] REG_PROG_TOP = 2'd0;
  localparam logic [1:0] REG_MAP_BASE = 2'd1;
  localparam logic [1:0] REG_MEM_KB   = 2'd2;

  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_NOP, OP_ADD, OP_ALLOC, OP_FREE, OP_SHRINK, OP_GROW, OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] slot;
    logic [7:0] page;
    logic [4:0] idx;
    logic [4:0] start;
    logic [4:0] lim;
  } item_t;

  function automatic logic [4:0] bank_count(input logic [15:0] v, input logic [15:0] base);
    logic [15:0] d;
    logic [5:0]  n;
    d = v + 16'hFFFF - base;
    n = {1'b0, d[15:11]} + 6'd1;
    return (n > {1'b0, BANK_LIMIT}) ? BANK_LIMIT : n[4:0];
  endfunction

  function automatic logic [7:0] ent_reset(input logic [4:0] e);
    logic [7:0] v;
    case (e)
      ENT_COMMON: v = COMMON_PAGE;
      ENT_IO_LO:  v = IO_PAGE_LO;
      ENT_IO_HI:  v = IO_PAGE_HI;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/page_frame_map_allocator.sv
`default_nettype none
// Page frame allocator: a free stack of 2K pages and a 32-entry page table per
// process slot. Commands enter through a two-deep queue and are carried out by
// a sequencer over table and stack memories with one write and one read port
// each. Alloc and a growing realloc pop one page per entry; alloc then fills
// the remaining entries with the last page, and free walks every banked entry.
// After reset the tables are initialised by a pass over every slot and entry,
// during which full stays high. One result per command; the result register
// lets further commands queue while it waits to be popped.
module page_frame_map_allocator import pfma_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  cmd,
  input  wire logic [3:0]  slot,
  input  wire logic [7:0]  page,
  input  wire logic [15:0] top,
  input  wire logic [15:0] new_size,
  input  wire logic [4:0]  entry_index,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic [7:0]       page_out,
  output logic [8:0]       free_count,
  output logic [9:0]       mem_used_kb,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] prog_top;
  logic [15:0] map_base;
  logic [9:0]  mem_total_kb;
  item_t       f_item;
  item_t       q_item;
  logic        q_full;
  logic        q_valid;
  logic        q_rd;
  logic        clearing;
  logic        res_valid;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full || clearing;
  assign accept    = push && !full;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_top     <= 16'hE800;
      map_base     <= 16'h0100;
      mem_total_kb <= 10'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROG_TOP: prog_top     <= cfg_data;
        REG_MAP_BASE: map_base     <= cfg_data;
        REG_MEM_KB:   mem_total_kb <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  pfma_front u_front (
    .cmd, .slot, .page, .top, .new_size, .entry_index,
    .prog_top, .map_base, .item(f_item)
  );

  pfma_queue u_queue (
    .clk, .rst, .wr(accept), .din(f_item), .q_full,
    .rd(q_rd), .q_valid, .dout(q_item)
  );

  pfma_back u_back (
    .clk, .rst, .q_valid, .q_item, .q_rd, .mem_total_kb, .clearing,
    .res_valid, .res_pop(pop), .res_status(status), .res_page(page_out),
    .res_free(free_count), .res_used(mem_used_kb)
  );

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst) clearing |-> full)
    else $error("input accepted during table initialisation");
  a_fc_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> free_count <= 9'(FREE_DEPTH))
    else $error("free count beyond stack depth");
  a_status: assert property (@(posedge clk) disable iff (rst) !empty |-> status != 2'd3)
    else $error("bad status code");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(free_count)))
    else $error("waiting result changed");
`endif

endmodule
`default_nettype wire

### sv/pfma_front.sv
`default_nettype none
module pfma_front import pfma_pkg::*; (
  input  wire logic [2:0]  cmd,
  input  wire logic [3:0]  slot,
  input  wire logic [7:0]  page,
  input  wire logic [15:0] top,
  input  wire logic [15:0] new_size,
  input  wire logic [4:0]  entry_index,
  input  wire logic [15:0] prog_top,
  input  wire logic [15:0] map_base,
  output item_t            item
);

  logic [4:0] have;
  logic [4:0] want;

  always_comb begin
    have = bank_count(top, prog_top);
    want = bank_count(new_size + map_base, prog_top);
    item.slot  = slot;
    item.page  = page;
    item.idx   = entry_index;
    item.op    = OP_NOP;
    item.start = 5'd0;
    item.lim   = have;
    if (int'(slot) < SLOTS) begin
      unique case (cmd)
        CMD_ADD:   item.op = OP_ADD;
        CMD_ALLOC: item.op = OP_ALLOC;
        CMD_FREE:  item.op = OP_FREE;
        CMD_REALLOC: begin
          if (want < have) begin
            item.op    = OP_SHRINK;
            item.start = want;
            item.lim   = have;
          end else if (want > have) begin
            item.op    = OP_GROW;
            item.start = have;
            item.lim   = want;
          end
        end
        CMD_READ:  item.op = OP_READ;
        default:   item.op = OP_NOP;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/pfma_queue.sv
`default_nettype none
module pfma_queue import pfma_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  wire item_t din,
  output logic       q_full,
  input  wire logic  rd,
  output logic       q_valid,
  output item_t      dout
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         mem [QDEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;

  assign q_full  = (cnt == CW'(QDEPTH));
  assign q_valid = (cnt != '0);
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= din;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == PW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == PW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CW'(wr) - CW'(rd);
    end
  end

endmodule
`default_nettype wire

### sv/pfma_back.sv
`default_nettype none
module pfma_back import pfma_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire item_t      q_item,
  output logic            q_rd,
  input  wire logic [9:0] mem_total_kb,
  output logic            clearing,
  output logic            res_valid,
  input  wire logic       res_pop,
  output logic [1:0]      res_status,
  output logic [7:0]      res_page,
  output logic [8:0]      res_free,
  output logic [9:0]      res_used
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD, S_APOP, S_AWR, S_AFILL, S_FRD, S_FCHK,
    S_RRDF, S_RGETF, S_RRD, S_RSH, S_READ, S_RDATA, S_DONE
  } state_t;

  state_t            state;
  item_t             cur;
  logic [FC_W-1:0]   fc;
  logic [4:0]        i;
  logic [7:0]        last;
  logic [7:0]        fill;
  logic              fill_mode;
  logic [1:0]        status;
  logic [7:0]        page_q;
  logic [TBL_AW-1:0] clr;

  logic [7:0] tbl [SLOTS*ENTRIES];
  logic [7:0] stk [FREE_DEPTH];
  logic [7:0] tbl_q;
  logic [7:0] stk_q;

  logic              tw_en;
  logic [TBL_AW-1:0] tw_addr;
  logic [7:0]        tw_data;
  logic [TBL_AW-1:0] tr_addr;
  logic              sw_en;
  logic [7:0]        sw_data;
  logic [FS_AW-1:0]  sr_addr;
  logic              can_push;
  logic [4:0]        need;
  logic [9:0]        dbl;
  logic [SLOT_AW-1:0] sl;

  assign can_push = (fc < FC_W'(FREE_DEPTH));
  assign sr_addr  = FS_AW'(fc - 1'b1);
  assign need     = q_item.lim - q_item.start;
  assign dbl      = {1'b0, 9'(fc)} << 1;
  assign clearing = (state == S_CLEAR);
  assign q_rd     = (state == S_IDLE) && q_valid && !res_valid;
  assign sl       = SLOT_AW'(cur.slot);

  always_comb begin
    tw_en   = 1'b0;
    tw_addr = {sl, i};
    tw_data = stk_q;
    tr_addr = {sl, i};
    sw_en   = 1'b0;
    sw_data = cur.page;
    unique case (state)
      S_CLEAR: begin
        tw_en   = 1'b1;
        tw_addr = clr;
        tw_data = ent_reset(clr[ENT_AW-1:0]);
      end
      S_ADD:   sw_en = can_push;
      S_AWR:   tw_en = 1'b1;
      S_AFILL: begin
        tw_en   = 1'b1;
        tw_data = last;
      end
      S_FCHK: begin
        sw_en   = can_push && (tbl_q != last);
        sw_data = tbl_q;
      end
      S_RRDF:  tr_addr = {sl, LAST_BANK};
      S_RSH: begin
        sw_en   = can_push;
        sw_data = tbl_q;
        tw_en   = 1'b1;
        tw_data = fill;
      end
      S_READ:  tr_addr = {sl, cur.idx};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      tbl[tw_addr] <= tw_data;
    end
    tbl_q <= tbl[tr_addr];
    if (sw_en) begin
      stk[FS_AW'(fc)] <= sw_data;
    end
    stk_q <= stk[sr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      fc        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == TBL_AW'(SLOTS*ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_rd) begin
            cur       <= q_item;
            status    <= ST_OK;
            page_q    <= 8'h00;
            i         <= q_item.start;
            last      <= 8'h00;
            fill_mode <= (q_item.op == OP_ALLOC);
            unique case (q_item.op)
              OP_ADD:    state <= S_ADD;
              OP_ALLOC, OP_GROW: begin
                if (FC_W'(need) > fc) begin
                  status <= ST_NO_MEM;
                  state  <= S_DONE;
                end else begin
                  state <= S_APOP;
                end
              end
              OP_FREE:   state <= S_FRD;
              OP_SHRINK: state <= S_RRDF;
              OP_READ:   state <= S_READ;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_ADD: begin
          if (can_push) begin
            fc <= fc + 1'b1;
          end else begin
            status <= ST_OVERFLOW;
          end
          state <= S_DONE;
        end
        S_APOP: begin
          fc    <= fc - 1'b1;
          state <= S_AWR;
        end
        S_AWR: begin
          last <= stk_q;
          i    <= i + 1'b1;
          if (i + 5'd1 == cur.lim) begin
            state <= (fill_mode && (i + 5'd1 < BANK_LIMIT)) ? S_AFILL : S_DONE;
          end else begin
            state <= S_APOP;
          end
        end
        S_AFILL: begin
          i <= i + 1'b1;
          if (i == LAST_BANK) begin
            state <= S_DONE;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (tbl_q != last) begin
            last <= tbl_q;
            if (can_push) begin
              fc <= fc + 1'b1;
            end else begin
              status <= ST_OVERFLOW;
            end
          end
          i <= i + 1'b1;
          state <= (i == LAST_BANK) ? S_DONE : S_FRD;
        end
        S_RRDF:  state <= S_RGETF;
        S_RGETF: begin
          fill  <= tbl_q;
          state <= S_RRD;
        end
        S_RRD:   state <= S_RSH;
        S_RSH: begin
          if (can_push) begin
            fc <= fc + 1'b1;
          end else begin
            status <= ST_OVERFLOW;
          end
          i <= i + 1'b1;
          state <= (i + 5'd1 == cur.lim) ? S_DONE : S_RRD;
        end
        S_READ:  state <= S_RDATA;
        S_RDATA: begin
          page_q <= tbl_q;
          state  <= S_DONE;
        end
        S_DONE: begin
          res_valid  <= 1'b1;
          res_status <= status;
          res_page   <= page_q;
          res_free   <= 9'(fc);
          res_used   <= (mem_total_kb > dbl) ? mem_total_kb - dbl : 10'd0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
module tb_top import pfma_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0] status;
    logic [7:0] page_out;
    logic [8:0] free_count;
    logic [9:0] mem_used_kb;
  } alloc_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [2:0] cmd = '0;
  logic [3:0] slot = '0;
  logic [7:0] page = '0;
  logic [15:0] top = '0;
  logic [15:0] new_size = '0;
  logic [4:0] entry_index = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] status;
  logic [7:0] page_out;
  logic [8:0] free_count;
  logic [9:0] mem_used_kb;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  page_frame_map_allocator u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow allocator state
  logic [7:0] m_stack [FREE_DEPTH];
  int unsigned m_fc;
  logic [7:0] m_tbl [SLOTS][ENTRIES];
  logic [15:0] m_prog_top, m_map_base;
  logic [9:0] m_mem_kb;

  alloc_resp_t resp_q[$];
  int errors = 0;
  int sent = 0;
  int got = 0;
  int send_idle = 0;
  int pop_idle = 0;
  int stall_cnt = 0;

  function automatic int unsigned banks(logic [15:0] v);
    logic [15:0] d;
    int unsigned n;
    d = v + 16'hFFFF - m_prog_top;
    n = int'(d[15:11]) + 1;
    return (n > 29) ? 29 : n;
  endfunction

  function automatic bit stack_push(logic [7:0] p);
    if (m_fc >= FREE_DEPTH) return 1'b0;
    m_stack[m_fc] = p;
    m_fc++;
    return 1'b1;
  endfunction

  function automatic logic [7:0] stack_pop();
    m_fc--;
    return m_stack[m_fc];
  endfunction

  function automatic alloc_resp_t predict_cmd(logic [2:0] c, logic [3:0] s, logic [7:0] p,
                                              logic [15:0] t, logic [15:0] ns,
                                              logic [4:0] ix);
    alloc_resp_t r;
    int unsigned n, have, want, i, used;
    logic [7:0] last, fill;
    r.status = ST_OK;
    r.page_out = '0;
    case (c)
      CMD_ADD: if (!stack_push(p)) r.status = ST_OVERFLOW;
      CMD_ALLOC: begin
        n = banks(t);
        if (n > m_fc) r.status = ST_NO_MEM;
        else begin
          for (i = 0; i < n; i++) m_tbl[s][i] = stack_pop();
          for (i = n; i < 29; i++) m_tbl[s][i] = m_tbl[s][i-1];
        end
      end
      CMD_FREE: begin
        last = 8'h00;
        for (i = 0; i < 29; i++)
          if (m_tbl[s][i] != last) begin
            last = m_tbl[s][i];
            if (!stack_push(last)) r.status = ST_OVERFLOW;
          end
      end
      CMD_REALLOC: begin
        have = banks(t);
        want = banks(ns + m_map_base);
        if (want < have) begin
          fill = m_tbl[s][28];
          for (i = want; i < have; i++) begin
            if (!stack_push(m_tbl[s][i])) r.status = ST_OVERFLOW;
            m_tbl[s][i] = fill;
          end
        end else if (want > have) begin
          if (want - have > m_fc) r.status = ST_NO_MEM;
          else for (i = have; i < want; i++) m_tbl[s][i] = stack_pop();
        end
      end
      CMD_READ: r.page_out = m_tbl[s][ix];
      default: ;
    endcase
    used = 2 * m_fc;
    used = (m_mem_kb > used) ? m_mem_kb - used : 0;
    r.free_count = m_fc[8:0];
    r.mem_used_kb = used[9:0];
    return r;
  endfunction

  task automatic send_cmd(logic [2:0] c, logic [3:0] s, logic [7:0] p, logic [15:0] t,
                          logic [15:0] ns, logic [4:0] ix);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c; slot <= s; page <= p; top <= t; new_size <= ns; entry_index <= ix;
    @(posedge clk);
    while (full) @(posedge clk);
    resp_q.push_back(predict_cmd(c, s, p, t, ns, ix));
    sent++;
  endtask

  task automatic write_reg(logic [1:0] ix, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (ix)
      REG_PROG_TOP: m_prog_top = d;
      REG_MAP_BASE: m_map_base = d;
      default: m_mem_kb = d[9:0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // top for a bank count of n under the current prog_top
  function automatic logic [15:0] top_for(int unsigned n);
    return m_prog_top + 16'((n - 1) * 2048) + 16'($urandom_range(2047));
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      pop <= ($urandom_range(99) >= pop_idle);
      if (pop && !empty) begin
        got++;
        if (resp_q.size() == 0) begin
          $error("result with nothing pending");
          errors++;
        end else begin
          alloc_resp_t e;
          e = resp_q.pop_front();
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status); errors++;
          end
          if (page_out !== e.page_out) begin
            $error("page_out exp %0h got %0h", e.page_out, page_out); errors++;
          end
          if (free_count !== e.free_count) begin
            $error("free_count exp %0d got %0d", e.free_count, free_count); errors++;
          end
          if (mem_used_kb !== e.mem_used_kb) begin
            $error("mem_used_kb exp %0d got %0d", e.mem_used_kb, mem_used_kb); errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    int i;
    for (i = 0; i < 4; i++) send_cmd(CMD_READ, 4'(i), 8'h00, '0, '0, 5'(28 + i));
    send_cmd(CMD_ALLOC, 4'd0, '0, 16'hFFFF, '0, '0);
    send_cmd(CMD_ADD, 4'd1, 8'hFF, '0, '0, '0);
    send_cmd(CMD_ADD, 4'd1, 8'h00, '0, '0, '0);
    for (i = 0; i < 6; i++) send_cmd(CMD_ADD, 4'd15, 8'(8'h40 + i), '0, '0, '0);
    send_cmd(CMD_ALLOC, 4'd15, '0, m_prog_top + 16'd4096, '0, '0);
    send_cmd(CMD_READ, 4'd15, '0, '0, '0, 5'd0);
    send_cmd(CMD_READ, 4'd15, '0, '0, '0, 5'd28);
    send_cmd(CMD_REALLOC, 4'd15, '0, m_prog_top + 16'd4096, 16'hFFFF, '0);
    send_cmd(CMD_REALLOC, 4'd15, '0, m_prog_top + 16'd4096,
             m_prog_top - m_map_base, '0);
    send_cmd(CMD_REALLOC, 4'd15, '0, m_prog_top, m_prog_top - m_map_base, '0);
    send_cmd(CMD_FREE, 4'd15, '0, '0, '0, '0);
    send_cmd(CMD_FREE, 4'd3, '0, '0, '0, '0);
    send_cmd(3'd5, 4'd2, 8'hAA, 16'hFFFF, 16'hFFFF, 5'd31);
    send_cmd(3'd7, 4'd2, 8'h55, '0, '0, '0);
    send_cmd(CMD_READ, 4'd15, '0, '0, '0, 5'd31);
    drain();
  endtask

  task automatic test_overflow();
    int i;
    while (m_fc < FREE_DEPTH) send_cmd(CMD_ADD, 4'($urandom_range(15)), 8'($urandom), '0, '0, '0);
    send_cmd(CMD_ADD, 4'd0, 8'h12, '0, '0, '0);
    send_cmd(CMD_FREE, 4'd15, '0, '0, '0, '0);
    for (i = 0; i < 9; i++) send_cmd(CMD_ALLOC, 4'(i), '0, 16'($urandom), '0, '0);
    send_cmd(CMD_REALLOC, 4'd0, '0, m_prog_top - 16'd1, '0, '0);
    drain();
  endtask

  task automatic test_random(int count);
    int k;
    int unsigned r;
    logic [3:0] s;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99);
      s = 4'($urandom);
      if (m_fc > 200 && r < 40) r = 60;
      if (r < 40)
        send_cmd(CMD_ADD, s, 8'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
      else if (r < 50)
        send_cmd(CMD_ALLOC, s, 8'($urandom),
                 ($urandom_range(3) == 0) ? 16'($urandom) : top_for($urandom_range(1, 4)),
                 16'($urandom), 5'($urandom));
      else if (r < 56)
        send_cmd(CMD_FREE, s, 8'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
      else if (r < 64)
        send_cmd(CMD_REALLOC, s, 8'($urandom), top_for($urandom_range(1, 4)),
                 ($urandom_range(3) == 0) ? 16'($urandom) :
                   top_for($urandom_range(1, 5)) - m_map_base,
                 5'($urandom));
      else if (r < 97)
        send_cmd(CMD_READ, s, 8'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
      else
        send_cmd(3'($urandom_range(5, 7)), s, 8'($urandom), 16'($urandom),
                 16'($urandom), 5'($urandom));
    end
    drain();
  endtask

  task automatic test_config(logic [15:0] pt, logic [15:0] mb, logic [15:0] kb, int count);
    write_reg(REG_PROG_TOP, pt);
    write_reg(REG_MAP_BASE, mb);
    write_reg(REG_MEM_KB, kb);
    test_random(count);
  endtask

  initial begin
    m_fc = 0;
    m_prog_top = 16'hE800;
    m_map_base = 16'h0100;
    m_mem_kb = 10'd256;
    for (int s = 0; s < SLOTS; s++)
      for (int e = 0; e < ENTRIES; e++)
        m_tbl[s][e] = (e == 29) ? COMMON_PAGE : (e == 30) ? IO_PAGE_LO :
                      (e == 31) ? IO_PAGE_HI : 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    send_idle = 0;   pop_idle = 0;  test_random(300);
    send_idle = 63;  pop_idle = 0;  test_config(16'h0000, 16'h0000, 16'd512, 250);
    send_idle = 0;   pop_idle = 63; test_config(16'hFFFF, 16'hFFFF, 16'd0, 250);
    send_idle = 12;  pop_idle = 12; test_config(16'h8000, 16'h1234, 16'd1023, 250);
    send_idle = 0;   pop_idle = 0;  test_config(16'hE800, 16'h0100, 16'd256, 300);
    $display("ran %0d commands (%0d results) over five register settings", sent, got);
    $display("covered add/alloc/free/realloc/read, overflow, no-memory and idle patterns");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
